// File: design/b2b100_pkg.sv
// Shared types and constants of the binary to base-100 mantissa converter.
package b2b100_pkg;

    localparam int NUM_DIGITS  = 20;
    localparam int DIG_W       = 4;
    localparam int BCD_W       = NUM_DIGITS * DIG_W;
    localparam int VALUE_W     = 64;
    localparam int STAGE_BITS  = 8;
    localparam int NUM_STAGES  = VALUE_W / STAGE_BITS;
    localparam int OP_W        = 2;
    localparam int SIGN_W      = 2;
    localparam int EXP_W       = 5;
    localparam int CNT_W       = 5;
    localparam int PAIR_W      = 7;
    localparam int LEFT_W      = 4;
    localparam int OUT_FIELDS_W = SIGN_W + EXP_W + CNT_W + PAIR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_U32     = 2'd0,
        OP_S32     = 2'd1,
        OP_U64     = 2'd2,
        OP_U64_ALT = 2'd3
    } op_t;

    localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
    localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
    localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

    typedef struct packed {
        logic [SIGN_W-1:0] sgn;
        logic [BCD_W-1:0]  bcd;
    } conv_item_t;

endpackage

// File: design/b2b100_conv.sv
// Pipelined binary to packed decimal conversion, eight input bits per stage.
module b2b100_conv
    import b2b100_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  op_t                op,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    output conv_item_t         out_item
);

    logic             valid_reg [NUM_STAGES+1];
    conv_item_t       item_reg  [NUM_STAGES+1];
    logic [VALUE_W-1:0] bin_reg [NUM_STAGES];

    logic [VALUE_W-1:0] mag;
    logic [SIGN_W-1:0]  sgn;
    logic [31:0]        lo_word;

    function automatic logic [BCD_W-1:0] dabble_byte(
        input logic [BCD_W-1:0]      bcd_in,
        input logic [STAGE_BITS-1:0] bits
    );
        logic [BCD_W-1:0] acc;
        acc = bcd_in;
        for (int s = STAGE_BITS - 1; s >= 0; s--) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (acc[d*DIG_W +: DIG_W] >= 4'd5) begin
                    acc[d*DIG_W +: DIG_W] = acc[d*DIG_W +: DIG_W] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[s]};
        end
        return acc;
    endfunction

    always_comb
    begin
        lo_word = value[31:0];
        case (op)
            OP_U32:
            begin
                mag = {32'd0, lo_word};
                sgn = SIGN_POS;
            end
            OP_S32:
            begin
                if (lo_word[31])
                begin
                    mag = {32'd0, (~lo_word) + 32'd1};
                    sgn = SIGN_NEG;
                end
                else
                begin
                    mag = {32'd0, lo_word};
                    sgn = SIGN_POS;
                end
            end
            default:
            begin
                mag = value;
                sgn = SIGN_POS;
            end
        endcase
        if (mag == '0)
        begin
            sgn = SIGN_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NUM_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= NUM_STAGES; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0].sgn <= sgn;
            item_reg[0].bcd <= '0;
            bin_reg[0]      <= mag;
            for (int i = 1; i <= NUM_STAGES; i++)
            begin
                item_reg[i].sgn <= item_reg[i-1].sgn;
                item_reg[i].bcd <= dabble_byte(item_reg[i-1].bcd,
                                               bin_reg[i-1][VALUE_W-1 -: STAGE_BITS]);
                if (i < NUM_STAGES)
                begin
                    bin_reg[i] <= bin_reg[i-1] << STAGE_BITS;
                end
            end
        end
    end

    assign out_valid = valid_reg[NUM_STAGES];
    assign out_item  = item_reg[NUM_STAGES];

endmodule

// File: design/binary_to_base100_mantissa.sv
// Top level: binary integer in, normalized base-100 decimal mantissa out.
//
// Channel  Direction  tdata                                      tuser  tlast
// s_axis   in         value                                      op     -
// m_axis   out        sign, exponent, digit_count, digit_pair    -      last
//
// A transfer enters a thirteen-stage pipeline: one stage for the magnitude, eight
// stages of eight shift-and-adjust steps each, two stages for digit counting and
// alignment, then the pair sequencer and its output register.
// The pair sequencer sets the rate: it takes a new item only once the last pair of the current one has gone out.
// Reset clears all valid bits and the sequencer; no pass over storage follows.
// A stall on m_axis holds the output register; the pipeline and s_axis_tready
// are held whenever the sequencer is busy and the last stage holds an item.
module binary_to_base100_mantissa
    import b2b100_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [VALUE_W-1:0]     s_axis_tdata,  // value
    input  logic [OP_W-1:0]        s_axis_tuser,  // op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // sign, exponent, digit_count, digit_pair
    output logic                   m_axis_tlast   // last
);

    logic       en;
    logic       conv_valid;
    conv_item_t conv_item;

    logic             va_reg;
    logic [SIGN_W-1:0] sgna_reg;
    logic [BCD_W-1:0] bcda_reg;
    logic [EXP_W-1:0] lza_reg;
    logic [EXP_W-1:0] tza_reg;
    logic [EXP_W-1:0] lz_next;
    logic [EXP_W-1:0] tz_next;

    logic              vb_reg;
    logic [SIGN_W-1:0] sgnb_reg;
    logic [BCD_W-1:0]  digb_reg;
    logic [EXP_W-1:0]  expb_reg;
    logic [CNT_W-1:0]  cntb_reg;
    logic [LEFT_W-1:0] npb_reg;
    logic [BCD_W-1:0]  digb_next;
    logic [EXP_W-1:0]  expb_next;
    logic [CNT_W-1:0]  cntb_next;
    logic [CNT_W-1:0]  cnt_round;

    logic              busy_reg;
    logic              busy_next;
    logic [LEFT_W-1:0] left_reg;
    logic [LEFT_W-1:0] left_next;
    logic [BCD_W-1:0]  dig_reg;
    logic [BCD_W-1:0]  dig_next;
    logic [SIGN_W-1:0] sgne_reg;
    logic [EXP_W-1:0]  expe_reg;
    logic [CNT_W-1:0]  cnte_reg;

    logic              ovalid_reg;
    logic              ovalid_next;
    logic [SIGN_W-1:0] osign_reg;
    logic [EXP_W-1:0]  oexp_reg;
    logic [CNT_W-1:0]  ocnt_reg;
    logic [PAIR_W-1:0] opair_reg;
    logic              olast_reg;
    logic [PAIR_W-1:0] pair_next;

    logic out_free;
    logic emit;
    logic load;

    assign out_free = !ovalid_reg || m_axis_tready;
    assign emit     = busy_reg && out_free;
    assign load     = vb_reg && !busy_reg;
    assign en       = !vb_reg || !busy_reg;

    assign s_axis_tready = en;

    b2b100_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .op        (op_t'(s_axis_tuser)),
        .value     (s_axis_tdata),
        .out_valid (conv_valid),
        .out_item  (conv_item)
    );

    always_comb
    begin
        logic found_hi;
        logic found_lo;
        found_hi = 1'b0;
        found_lo = 1'b0;
        lz_next  = EXP_W'(NUM_DIGITS);
        tz_next  = EXP_W'(NUM_DIGITS);
        for (int d = NUM_DIGITS - 1; d >= 0; d--)
        begin
            if (!found_hi && conv_item.bcd[d*DIG_W +: DIG_W] != 4'd0)
            begin
                lz_next  = EXP_W'(NUM_DIGITS - 1 - d);
                found_hi = 1'b1;
            end
        end
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (!found_lo && conv_item.bcd[d*DIG_W +: DIG_W] != 4'd0)
            begin
                tz_next  = EXP_W'(d);
                found_lo = 1'b1;
            end
        end
    end

    always_comb
    begin
        digb_next = bcda_reg << {lza_reg, 2'b00};
        expb_next = EXP_W'(NUM_DIGITS) - lza_reg;
        if (sgna_reg == SIGN_ZERO)
        begin
            cntb_next = CNT_W'(1);
        end
        else
        begin
            cntb_next = expb_next - tza_reg;
        end
        cnt_round = cntb_next + CNT_W'(1);
    end

    always_comb
    begin
        if (load)
        begin
            busy_next = 1'b1;
        end
        else if (emit && left_reg == LEFT_W'(1))
        begin
            busy_next = 1'b0;
        end
        else
        begin
            busy_next = busy_reg;
        end

        if (load)
        begin
            left_next = npb_reg;
            dig_next  = digb_reg;
        end
        else if (emit)
        begin
            left_next = left_reg - LEFT_W'(1);
            dig_next  = dig_reg << (2 * DIG_W);
        end
        else
        begin
            left_next = left_reg;
            dig_next  = dig_reg;
        end

        if (emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end

        pair_next = {dig_reg[BCD_W-1 -: DIG_W], 3'b000}
                  + {2'b00, dig_reg[BCD_W-1 -: DIG_W], 1'b0}
                  + {3'b000, dig_reg[BCD_W-DIG_W-1 -: DIG_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg     <= 1'b0;
            vb_reg     <= 1'b0;
            busy_reg   <= 1'b0;
            left_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                va_reg <= conv_valid;
                vb_reg <= va_reg;
            end
            busy_reg   <= busy_next;
            left_reg   <= left_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgna_reg <= conv_item.sgn;
            bcda_reg <= conv_item.bcd;
            lza_reg  <= lz_next;
            tza_reg  <= tz_next;
            sgnb_reg <= sgna_reg;
            digb_reg <= digb_next;
            expb_reg <= expb_next;
            cntb_reg <= cntb_next;
            npb_reg  <= cnt_round[CNT_W-1:1];
        end
        dig_reg <= dig_next;
        if (load)
        begin
            sgne_reg <= sgnb_reg;
            expe_reg <= expb_reg;
            cnte_reg <= cntb_reg;
        end
        if (emit)
        begin
            osign_reg <= sgne_reg;
            oexp_reg  <= expe_reg;
            ocnt_reg  <= cnte_reg;
            opair_reg <= pair_next;
            olast_reg <= (left_reg == LEFT_W'(1));
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                            opair_reg, ocnt_reg, oexp_reg, osign_reg};

`ifndef NO_ASSERTIONS
    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> opair_reg <= PAIR_W'(99))
        else $error("Digit pair exceeds 99.");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && osign_reg == SIGN_ZERO) |->
            (olast_reg && ocnt_reg == CNT_W'(1) && oexp_reg == '0 && opair_reg == '0))
        else $error("Zero result is not a single zero pair.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && osign_reg != SIGN_ZERO) |->
            (ocnt_reg != '0 && oexp_reg >= ocnt_reg))
        else $error("Digit count exceeds exponent.");

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (left_reg != '0 && left_reg <= LEFT_W'(NUM_DIGITS / 2)))
        else $error("Pair counter out of range while busy.");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && left_reg == LEFT_W'(1)) |=> (!busy_reg && m_axis_tlast))
        else $error("Final pair did not end the conversion.");
`endif

endmodule
